// File: design/crc32fr_pkg.sv
// ============================================================================
// crc32fr_pkg
// Shared types, constants and the CRC-32 byte update for the frame receiver.
// ============================================================================
`default_nettype none

package crc32fr_pkg;

    // Largest payload a frame may carry; longer length bytes are clipped.
    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = 7;
    localparam int SIZE_W      = 6;
    localparam int PADDR_W     = 3;

    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [31:0] PREAMBLE_RESET  = 32'hDDCC_BBAA;

    // Register word indexes on the configuration port.
    localparam logic REG_PREAMBLE = 1'b0;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_ADDR = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_DATA = 5'b01000,
        PH_CHK  = 5'b10000
    } t_phase;

    // Handed from the parser to the emitter when a frame passes its check.
    typedef struct packed {
        logic             go;
        logic [7:0]       src;
        logic [LEN_W-1:0] len;
    } t_run_start;

    // Payload store write port, driven by the parser.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/crc32fr_ram.sv
// ============================================================================
// crc32fr_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module crc32fr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/crc32fr_parser.sv
// ============================================================================
// crc32fr_parser
// Byte-wide frame parser: preamble hunt, header, payload capture and CRC check.
// ============================================================================
`default_nettype none

module crc32fr_parser (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_take,
    input  wire logic [7:0]              i_byte,
    input  wire logic [31:0]             i_preamble,
    output crc32fr_pkg::t_store_wr       o_wr,
    output crc32fr_pkg::t_run_start      o_start
);
    import crc32fr_pkg::*;

    t_phase            r_phase,  n_phase;
    logic [LEN_W-1:0]  r_count,  n_count;
    logic [31:0]       r_crc,    n_crc;
    logic [31:0]       r_rcv,    n_rcv;
    logic [7:0]        r_src,    n_src;
    logic [LEN_W-1:0]  r_len,    n_len;

    logic [1:0]        w_k;
    logic [7:0]        w_want;
    logic [7:0]        w_clip;
    logic [LEN_W-1:0]  w_count_inc;

    assign w_k         = r_count[1:0];
    assign w_want      = i_preamble[8*w_k +: 8];
    assign w_clip      = (i_byte > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : i_byte;
    assign w_count_inc = r_count + LEN_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_crc   = r_crc;
        n_rcv   = r_rcv;
        n_src   = r_src;
        n_len   = r_len;
        o_wr    = '{en: 1'b0, addr: r_count[ADDR_W-1:0], data: i_byte};
        o_start = '{go: 1'b0, src: r_src, len: r_len};

        if (i_take) begin
            case (r_phase)
                PH_ADDR: begin
                    n_crc = crc32_byte(r_crc, i_byte);
                    if (r_count == '0) begin
                        n_count = LEN_W'(1);
                    end else begin
                        n_src   = i_byte;
                        n_count = '0;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len   = w_clip[LEN_W-1:0];
                    n_crc   = crc32_byte(r_crc, w_clip);
                    n_count = '0;
                    n_rcv   = '0;
                    n_phase = (w_clip == 8'd0) ? PH_CHK : PH_DATA;
                end
                PH_DATA: begin
                    // The clipped length keeps the count inside the store.
                    o_wr.en = 1'b1;
                    n_crc   = crc32_byte(r_crc, i_byte);
                    n_count = w_count_inc;
                    if (w_count_inc >= r_len) begin
                        n_count = '0;
                        n_rcv   = '0;
                        n_phase = PH_CHK;
                    end
                end
                PH_CHK: begin
                    n_rcv   = r_rcv | ({24'h0, i_byte} << (8 * w_k));
                    n_count = w_count_inc;
                    if (w_k == 2'd3) begin
                        o_start.go = ((r_crc ^ CRC_INIT) == n_rcv);
                        n_count    = '0;
                        n_crc      = CRC_INIT;
                        n_phase    = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (i_byte == w_want) begin
                        n_crc = crc32_byte((w_k == 2'd0) ? CRC_INIT : r_crc, i_byte);
                        if (w_k == 2'd3) begin
                            n_count = '0;
                            n_phase = PH_ADDR;
                        end else begin
                            n_count = LEN_W'(w_k) + LEN_W'(1);
                        end
                    end else begin
                        // The mismatching byte is not retried as a first byte.
                        n_count = '0;
                        n_crc   = CRC_INIT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_rcv   <= '0;
            r_src   <= '0;
            r_len   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_rcv   <= n_rcv;
            r_src   <= n_src;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

// File: design/crc32fr_emit.sv
// ============================================================================
// crc32fr_emit
// Plays an accepted frame out of the payload store, one result per transfer.
// ============================================================================
`default_nettype none

module crc32fr_emit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire crc32fr_pkg::t_run_start      i_start,
    output logic                              o_busy,
    output logic                              o_rd_en,
    output logic [crc32fr_pkg::ADDR_W-1:0]    o_rd_addr,
    input  wire logic [7:0]                   i_rd_data,
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output logic [7:0]                        o_source_address,
    output logic [crc32fr_pkg::SIZE_W-1:0]    o_payload_size,
    output logic [7:0]                        o_payload_byte,
    output logic                              o_byte_valid,
    output logic                              o_last
);
    import crc32fr_pkg::*;

    logic              r_active, n_active;
    logic [LEN_W-1:0]  r_idx,    n_idx;
    logic [LEN_W-1:0]  r_len;
    logic [7:0]        r_src;
    logic              r_valid,  n_valid;
    logic              r_bv,     r_last;
    logic [7:0]        r_osrc;
    logic [SIZE_W-1:0] r_osize;

    logic              w_issue;
    logic              w_empty;
    logic              w_final;

    // The store read data is the output register for the payload byte: a read
    // is issued only when the output slot is free or leaves at this edge.
    assign w_issue   = r_active && (!r_valid || !i_stall);
    assign w_empty   = (r_len == '0);
    assign w_final   = w_empty || ((r_idx + LEN_W'(1)) == r_len);
    assign o_rd_en   = w_issue && !w_empty;
    assign o_rd_addr = r_idx[ADDR_W-1:0];

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        n_valid  = r_valid && i_stall;
        if (w_issue) begin
            n_valid = 1'b1;
            n_idx   = r_idx + LEN_W'(1);
            if (w_final) begin
                n_active = 1'b0;
            end
        end
        if (i_start.go) begin
            n_active = 1'b1;
            n_idx    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start.go) begin
            r_src <= i_start.src;
            r_len <= i_start.len;
        end
        if (w_issue) begin
            r_osrc  <= r_src;
            r_osize <= r_len[SIZE_W-1:0];
            r_bv    <= !w_empty;
            r_last  <= w_final;
        end
    end

    assign o_busy           = r_active;
    assign o_valid          = r_valid;
    assign o_source_address = r_osrc;
    assign o_payload_size   = r_osize;
    assign o_payload_byte   = r_bv ? i_rd_data : 8'h00;
    assign o_byte_valid     = r_bv;
    assign o_last           = r_last;

endmodule

`default_nettype wire

// File: design/crc32_frame_receiver.sv
// ============================================================================
// crc32_frame_receiver
// Preamble / length / CRC-32 frame receiver that replays good frames.
// ============================================================================
//
//  Channel   Handshake             Payload
//  -------   -------------------   ---------------------------------------------
//  rx in     i_valid / o_stall     i_rx_byte
//  result    o_valid / i_stall     o_source_address, o_payload_size,
//                                  o_payload_byte, o_byte_valid, o_last
//  config    psel/penable/pready   paddr, pwrite, pwdata, prdata
//
//  While a frame is being received, one byte is taken per cycle.
//  A good frame is replayed from the payload RAM at one result per cycle while
//  i_stall is low, max(length, 1) results in all, and the input is stalled
//  from the edge after the last CRC byte until the final result's read has
//  been issued. The RAM's single read port sets that pace.
//  Reset is synchronous; the payload RAM is not cleared.
// ============================================================================
`default_nettype none

module crc32_frame_receiver (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [7:0]                       i_rx_byte,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [7:0]                            o_source_address,
    output logic [crc32fr_pkg::SIZE_W-1:0]        o_payload_size,
    output logic [7:0]                            o_payload_byte,
    output logic                                  o_byte_valid,
    output logic                                  o_last,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [crc32fr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import crc32fr_pkg::*;

    logic [31:0]       r_preamble;
    logic              w_take;
    logic              w_busy;
    t_store_wr         w_wr;
    t_run_start        w_start;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [7:0]        w_rd_data;
    logic              w_reg_sel;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == REG_PREAMBLE);
    assign prdata    = w_reg_sel ? r_preamble : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble <= PREAMBLE_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_preamble <= pwdata;
        end
    end

    assign o_stall = w_busy;
    assign w_take  = i_valid && !w_busy;

    crc32fr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_byte     (i_rx_byte),
        .i_preamble (r_preamble),
        .o_wr       (w_wr),
        .o_start    (w_start)
    );

    // Writes and reads never overlap: input is held off while a run is read.
    crc32fr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr.en),
        .i_wr_addr (w_wr.addr),
        .i_wr_data (w_wr.data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    crc32fr_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (w_start),
        .o_busy           (w_busy),
        .o_rd_en          (w_rd_en),
        .o_rd_addr        (w_rd_addr),
        .i_rd_data        (w_rd_data),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_source_address (o_source_address),
        .o_payload_size   (o_payload_size),
        .o_payload_byte   (o_payload_byte),
        .o_byte_valid     (o_byte_valid),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

// File: design/crc32fr_chk.sv
// ============================================================================
// crc32fr_chk
// Port-level checks for the frame receiver, bound to the top level.
// ============================================================================
`default_nettype none

module crc32fr_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_stall,
    input wire logic                             o_valid,
    input wire logic                             i_stall,
    input wire logic [7:0]                       o_source_address,
    input wire logic [crc32fr_pkg::SIZE_W-1:0]   o_payload_size,
    input wire logic [7:0]                       o_payload_byte,
    input wire logic                             o_byte_valid,
    input wire logic                             o_last
);
    import crc32fr_pkg::*;

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte)
            && $stable(o_source_address) && $stable(o_last))
        else $error("stalled result changed");

    // An empty frame is a single result of size zero.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_last && (o_payload_size == '0))
        else $error("empty frame result malformed");

    // A data result belongs to a frame of nonzero size.
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid |-> (o_payload_size != '0))
        else $error("data result with zero size");

    // Until the final result is shown, no new byte may enter.
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input open during a run");

endmodule

bind crc32_frame_receiver crc32fr_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_source_address (o_source_address),
    .o_payload_size   (o_payload_size),
    .o_payload_byte   (o_payload_byte),
    .o_byte_valid     (o_byte_valid),
    .o_last           (o_last)
);

`default_nettype wire

// File: test/crc32_frame_receiver_checker.sv
// ============================================================================
// crc32_frame_receiver_checker
// Predicts and checks the result stream of the frame receiver.
//
// Follows every accepted rx transfer and every register write, keeps its own
// copy of the parser state and CRC, and queues the results that each good
// frame must replay. Each accepted result transfer is compared field by field
// with the oldest queued result.
// ============================================================================
`timescale 1ns / 100ps

package crc32_frame_tb_pkg;

    import crc32fr_pkg::*;

    // Reflected CRC-32 over one byte, one feedback bit per data bit.
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

endpackage

module crc32_frame_receiver_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_rx_valid,
    input  logic                                  i_rx_stall,
    input  logic [7:0]                            i_rx_byte,
    input  logic                                  i_res_valid,
    input  logic                                  i_res_stall,
    input  logic [7:0]                            i_source_address,
    input  logic [crc32fr_pkg::SIZE_W-1:0]        i_payload_size,
    input  logic [7:0]                            i_payload_byte,
    input  logic                                  i_byte_valid,
    input  logic                                  i_last,
    input  logic                                  i_psel,
    input  logic                                  i_penable,
    input  logic                                  i_pwrite,
    input  logic [crc32fr_pkg::PADDR_W-1:0]       i_paddr,
    input  logic [31:0]                           i_pwdata,
    input  logic                                  i_pready,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_frames_ok,
    output int                                    o_results_seen
);

    import crc32fr_pkg::*;
    import crc32_frame_tb_pkg::*;

    typedef struct packed {
        logic [7:0]        src;
        logic [SIZE_W-1:0] size;
        logic [7:0]        data;
        logic              byte_valid;
        logic              last;
    } t_replay;

    t_replay           replay_q[$];
    logic [31:0]       preamble;
    t_phase            phase;
    logic [LEN_W-1:0]  byte_idx;
    logic [31:0]       crc_acc;
    logic [31:0]       crc_rcvd;
    logic [7:0]        src_byte;
    logic [LEN_W-1:0]  frame_len;
    logic [7:0]        payload_mem [MAX_PAYLOAD];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_frames_ok    = 0;
        o_results_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("%0t ns: result %0d: %s", $time, o_results_seen, msg);
    endtask

    // Advances the parser by one accepted rx byte and queues the replay of a
    // frame whose checksum matches.
    task automatic absorb_rx_byte(input logic [7:0] b);
        int      k;
        t_replay r;
        case (phase)
            PH_ADDR: begin
                crc_acc = crc32_step(crc_acc, b);
                if (byte_idx == 0) begin
                    byte_idx = 1;
                end else begin
                    src_byte = b;
                    byte_idx = 0;
                    phase = PH_LEN;
                end
            end
            PH_LEN: begin
                // The CRC covers the clipped length, not the byte on the wire.
                frame_len = (b > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(b);
                crc_acc = crc32_step(crc_acc, 8'(frame_len));
                byte_idx = 0;
                crc_rcvd = 32'h0;
                phase = (frame_len == 0) ? PH_CHK : PH_DATA;
            end
            PH_DATA: begin
                if (byte_idx < MAX_PAYLOAD) begin
                    payload_mem[byte_idx[ADDR_W-1:0]] = b;
                end
                crc_acc = crc32_step(crc_acc, b);
                byte_idx = byte_idx + 1'b1;
                if (byte_idx >= frame_len) begin
                    byte_idx = 0;
                    crc_rcvd = 32'h0;
                    phase = PH_CHK;
                end
            end
            PH_CHK: begin
                crc_rcvd = crc_rcvd | (32'(b) << (8 * int'(byte_idx[1:0])));
                byte_idx = byte_idx + 1'b1;
                if (byte_idx >= 4) begin
                    if (~crc_acc == crc_rcvd) begin
                        o_frames_ok++;
                        if (frame_len == 0) begin
                            r = '{src: src_byte, size: '0, data: 8'h00,
                                  byte_valid: 1'b0, last: 1'b1};
                            replay_q.push_back(r);
                        end else begin
                            for (k = 0; k < int'(frame_len); k++) begin
                                r = '{src: src_byte, size: frame_len[SIZE_W-1:0],
                                      data: payload_mem[k], byte_valid: 1'b1,
                                      last: (k + 1 == int'(frame_len))};
                                replay_q.push_back(r);
                            end
                        end
                    end
                    byte_idx = 0;
                    crc_acc = CRC_INIT;
                    phase = PH_HUNT;
                end
            end
            default: begin
                // A mismatching byte restarts the hunt but is not itself
                // taken as a possible first preamble byte.
                k = int'(byte_idx[1:0]);
                phase = PH_HUNT;
                if (b == preamble[8*k +: 8]) begin
                    crc_acc = crc32_step((k == 0) ? CRC_INIT : crc_acc, b);
                    byte_idx = LEN_W'(k + 1);
                    if (byte_idx == 4) begin
                        byte_idx = 0;
                        phase = PH_ADDR;
                    end
                end else begin
                    byte_idx = 0;
                    crc_acc = CRC_INIT;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_replay want;
        if (!i_rst_n) begin
            preamble = PREAMBLE_RESET;
            phase = PH_HUNT;
            byte_idx = 0;
            crc_acc = CRC_INIT;
            crc_rcvd = 32'h0;
            src_byte = 8'h00;
            frame_len = 0;
            replay_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                o_results_seen++;
                if (replay_q.size() == 0) begin
                    report_mismatch($sformatf("transfer with nothing pending (source 0x%02h)",
                                              i_source_address));
                end else begin
                    want = replay_q.pop_front();
                    if (i_source_address !== want.src)
                        report_mismatch($sformatf("source_address 0x%02h, expected 0x%02h",
                                                  i_source_address, want.src));
                    if (i_payload_size !== want.size)
                        report_mismatch($sformatf("payload_size %0d, expected %0d",
                                                  i_payload_size, want.size));
                    if (i_payload_byte !== want.data)
                        report_mismatch($sformatf("payload_byte 0x%02h, expected 0x%02h",
                                                  i_payload_byte, want.data));
                    if (i_byte_valid !== want.byte_valid)
                        report_mismatch($sformatf("byte_valid %b, expected %b",
                                                  i_byte_valid, want.byte_valid));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b", i_last, want.last));
                end
            end
            if (i_rx_valid && !i_rx_stall) begin
                absorb_rx_byte(i_rx_byte);
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == PADDR_W'({REG_PREAMBLE, 2'b00})) begin
                preamble = i_pwdata;
            end
        end
        o_pending = replay_q.size();
    end

endmodule

// File: test/tb_crc32_frame_receiver.sv
// ============================================================================
// tb_crc32_frame_receiver
// Stimulus and verdict for the CRC-32 frame receiver.
//
// Sends framed byte streams under several preamble settings: empty, short,
// full-size and oversized frames, corrupted checksums, noise and preambles
// that break off. Both channels pause at random. The checker beside the
// block predicts and compares every result transfer.
// ============================================================================
`timescale 1ns / 100ps

module tb_crc32_frame_receiver;

    import crc32fr_pkg::*;
    import crc32_frame_tb_pkg::*;

    localparam int IDLE_LIMIT = 1000;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic [7:0]          i_rx_byte = 8'h00;
    logic                i_stall   = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [31:0]         pwdata    = 32'h0;

    logic                o_stall;
    logic                o_valid;
    logic [7:0]          o_source_address;
    logic [SIZE_W-1:0]   o_payload_size;
    logic [7:0]          o_payload_byte;
    logic                o_byte_valid;
    logic                o_last;
    logic [31:0]         prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  frames_ok;
    int                  results_seen;

    logic [31:0]         preamble = PREAMBLE_RESET;
    logic [31:0]         settings [4];
    bit                  quiet = 1'b0;
    int                  rx_sent = 0;
    int                  planned_results = 0;
    int                  idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    crc32_frame_receiver i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_source_address (o_source_address),
        .o_payload_size   (o_payload_size),
        .o_payload_byte   (o_payload_byte),
        .o_byte_valid     (o_byte_valid),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    crc32_frame_receiver_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_valid),
        .i_rx_stall       (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_source_address (o_source_address),
        .i_payload_size   (o_payload_size),
        .i_payload_byte   (o_payload_byte),
        .i_byte_valid     (o_byte_valid),
        .i_last           (o_last),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_frames_ok      (frames_ok),
        .o_results_seen   (results_seen)
    );

    // Result side: a random hold-off before each result transfer.
    always begin : result_stall
        int hold;
        hold = quiet ? 0 : $urandom_range(0, 15);
        repeat (hold) begin
            @(negedge i_clk);
            i_stall <= 1'b1;
        end
        @(negedge i_clk);
        i_stall <= 1'b0;
        do @(posedge i_clk); while (o_valid !== 1'b1);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("crc32_frame_receiver: mismatch");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        rx_sent++;
    endtask

    task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
                              input logic [7:0] len_byte, input bit bad_crc);
        logic [7:0]  bytes_q[$];
        logic [31:0] crc;
        logic [7:0]  b;
        int          clipped;
        int          k;
        quiet = ($urandom_range(0, 3) == 0);
        clipped = (len_byte > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len_byte);
        crc = CRC_INIT;
        for (k = 0; k < 4; k++) begin
            bytes_q.push_back(preamble[8*k +: 8]);
        end
        bytes_q.push_back(dest);
        bytes_q.push_back(src);
        foreach (bytes_q[i]) begin
            crc = crc32_step(crc, bytes_q[i]);
        end
        crc = crc32_step(crc, 8'(clipped));
        bytes_q.push_back(len_byte);
        for (k = 0; k < clipped; k++) begin
            b = 8'($urandom);
            crc = crc32_step(crc, b);
            bytes_q.push_back(b);
        end
        crc = ~crc;
        if (bad_crc) begin
            crc = crc ^ (32'h1 << $urandom_range(0, 31));
        end else begin
            planned_results += (clipped == 0) ? 1 : clipped;
        end
        for (k = 0; k < 4; k++) begin
            bytes_q.push_back(crc[8*k +: 8]);
        end
        foreach (bytes_q[i]) begin
            send_byte(bytes_q[i]);
        end
    endtask

    // Noise never holds the first preamble byte, so the hunt stays at its start.
    task automatic send_noise();
        logic [7:0] b;
        int         n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            do b = 8'($urandom); while (b == preamble[7:0]);
            send_byte(b);
        end
    endtask

    // A preamble that breaks off; the breaking byte is the first preamble
    // byte where possible, which must not start a new match.
    task automatic send_broken();
        logic [7:0] miss;
        int         k;
        int         i;
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++) begin
            send_byte(preamble[8*i +: 8]);
        end
        if (preamble[7:0] != preamble[8*k +: 8]) begin
            miss = preamble[7:0];
        end else begin
            miss = preamble[8*k +: 8] ^ 8'($urandom_range(1, 255));
        end
        send_byte(miss);
    endtask

    function automatic logic [7:0] random_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'($urandom_range(MAX_PAYLOAD + 1, 255));
        if (r == 2) return 8'(MAX_PAYLOAD);
        return 8'($urandom_range(1, 8));
    endfunction

    task automatic run_traffic(input int min_bytes, input int min_results);
        int bytes0;
        int results0;
        int pick;
        bytes0 = rx_sent;
        results0 = planned_results;
        while (rx_sent - bytes0 < min_bytes || planned_results - results0 < min_results) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_frame(8'($urandom), 8'($urandom), random_length(), 1'b0);
            end else if (pick == 7) begin
                send_frame(8'($urandom), 8'($urandom), random_length(), 1'b1);
            end else if (pick == 8) begin
                send_noise();
            end else begin
                send_broken();
            end
        end
    endtask

    // Waits until every queued result has gone out and the block is quiet.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_preamble(input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({REG_PREAMBLE, 2'b00});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        preamble = value;
    endtask

    initial begin
        settings[0] = 32'h0000_0000;
        settings[1] = 32'hFFFF_FFFF;
        settings[2] = $urandom;
        settings[3] = PREAMBLE_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A repeated first preamble byte breaks the match, then an empty frame,
        // then a frame whose checksum is wrong.
        send_byte(preamble[7:0]);
        send_byte(preamble[7:0]);
        send_frame(8'h00, 8'hFF, 8'h00, 1'b0);
        send_frame(8'hFF, 8'h00, 8'h01, 1'b1);

        send_frame(8'($urandom), 8'($urandom), 8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b0);
        foreach (settings[s]) begin
            settle();
            write_preamble(settings[s]);
            run_traffic(10, 1);
        end

        settle();
        repeat (32) @(negedge i_clk);
        $display("Sent %0d rx bytes under 5 preamble settings: empty, short, full and oversized",
                 rx_sent);
        $display("frames, bad checksums, noise and broken preambles; %0d frames, %0d results.",
                 frames_ok, results_seen);
        if (fail_count == 0) begin
            $display("crc32_frame_receiver: match");
        end else begin
            $display("crc32_frame_receiver: mismatch");
        end
        $finish;
    end

endmodule
